>>> rtl/pmc_pkg.sv
// Shared types and fixed field widths for the perfect matching counter.
`default_nettype none
package pmc_pkg;

  localparam int unsigned VERTEX_W = 4;   // width of a pair's vertex index
  localparam int unsigned CFG_W    = 5;   // width of the vertex count register
  localparam int unsigned COUNT_W  = 21;  // width of the matching count

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic cfg_write;  // take the configuration beat
    logic load;       // store the pair of the accepted item
    logic init;       // reset search state for a new case
    logic step;       // run one backtracking step
    logic clear;      // wipe the adjacency rows
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic found;      // the top level has another partner to try
    logic depth_one;  // only one live stack level
    logic n_zero;     // graph has no vertices
  } dp_status_t;

endpackage
`default_nettype wire

>>> rtl/pmc_ctrl.sv
// Sequencer of the perfect matching counter: load, search and report.
`default_nettype none
module pmc_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic                in_last_item,
  input  wire pmc_pkg::dp_status_t status,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  output pmc_pkg::dp_cmd_t         cmd,
  output logic                     busy,
  output logic                     out_valid
);

  pmc_pkg::state_t state_r;
  pmc_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pmc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    busy          = 1'b1;
    out_valid     = 1'b0;
    cfg_ready     = 1'b0;
    case (state_r)
      pmc_pkg::ST_IDLE: begin
        busy          = 1'b0;
        cfg_ready     = 1'b1;
        cmd.cfg_write = cfg_valid;
        cmd.load      = start;
        if (start && in_last_item) begin
          cmd.init  = 1'b1;
          state_nxt = status.n_zero ? pmc_pkg::ST_DONE : pmc_pkg::ST_SEARCH;
        end
      end
      pmc_pkg::ST_SEARCH: begin
        cmd.step = 1'b1;
        // popping the root level ends the search
        if (!status.found && status.depth_one) begin
          state_nxt = pmc_pkg::ST_DONE;
        end
      end
      pmc_pkg::ST_DONE: begin
        out_valid = 1'b1;
        cmd.clear = 1'b1;
        state_nxt = pmc_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = pmc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/pmc_datapath.sv
// Adjacency rows, search stack, matched mask and counter of the matching search.
`default_nettype none
module pmc_datapath #(
  parameter int unsigned MAX_V = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire pmc_pkg::dp_cmd_t              cmd,
  input  wire logic [pmc_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic [pmc_pkg::VERTEX_W-1:0]  in_vertex_a,
  input  wire logic [pmc_pkg::VERTEX_W-1:0]  in_vertex_b,
  input  wire logic                          in_pair_valid,
  output pmc_pkg::dp_status_t                status,
  output logic [pmc_pkg::COUNT_W-1:0]        count
);

  localparam int unsigned VW     = (MAX_V > 1) ? $clog2(MAX_V) : 1;
  localparam int unsigned LEVELS = MAX_V / 2 + 1;
  localparam int unsigned LW     = $clog2(LEVELS);
  localparam int unsigned DW     = $clog2(LEVELS + 1);
  localparam int unsigned CW     = pmc_pkg::CFG_W;
  localparam int unsigned VIW    = pmc_pkg::VERTEX_W;

  localparam logic [MAX_V-1:0] ONE_HOT0 = {{(MAX_V-1){1'b0}}, 1'b1};

  logic [CW-1:0]      vcount_r;
  logic [MAX_V-1:0]   adj_r [MAX_V];
  logic [VW-1:0]      stk_f_r [LEVELS];
  logic [VW-1:0]      stk_c_r [LEVELS];
  logic [DW-1:0]      depth_r;
  logic [MAX_V-1:0]   mask_r;
  logic               resume_r;
  logic [pmc_pkg::COUNT_W-1:0] count_r;

  logic [CW-1:0]      n_eff;
  logic [MAX_V-1:0]   below_n;
  logic [MAX_V-1:0]   above_c;
  logic               pair_ok;
  logic [VIW-1:0]     lo_v;
  logic [VIW-1:0]     hi_v;
  logic [LW-1:0]      top;
  logic [LW-1:0]      push_idx;
  logic [VW-1:0]      f;
  logic [VW-1:0]      c;
  logic [MAX_V-1:0]   base_mask;
  logic [MAX_V-1:0]   cand;
  logic               found;
  logic [VW-1:0]      cp;
  logic [MAX_V-1:0]   new_mask;
  logic [MAX_V-1:0]   free;
  logic               complete;
  logic [VW-1:0]      nf;

  assign n_eff = (vcount_r > CW'(MAX_V)) ? CW'(MAX_V) : vcount_r;

  always_comb begin
    for (int i = 0; i < MAX_V; i++) begin
      below_n[i] = (CW'(i) < n_eff);
    end
  end

  // pair filter: drop self pairs and indices past the vertex count
  assign pair_ok = in_pair_valid && (in_vertex_a != in_vertex_b) &&
                   ({1'b0, in_vertex_a} < n_eff) && ({1'b0, in_vertex_b} < n_eff);
  assign lo_v = (in_vertex_a < in_vertex_b) ? in_vertex_a : in_vertex_b;
  assign hi_v = (in_vertex_a < in_vertex_b) ? in_vertex_b : in_vertex_a;

  assign top      = LW'(depth_r - DW'(1));
  assign push_idx = LW'(depth_r);
  assign f        = stk_f_r[top];
  assign c        = stk_c_r[top];

  // after a pop, release the pair of the level that is now on top
  assign base_mask = resume_r ? (mask_r & ~((ONE_HOT0 << f) | (ONE_HOT0 << c))) : mask_r;

  always_comb begin
    for (int i = 0; i < MAX_V; i++) begin
      above_c[i] = (VW'(i) > c);
    end
  end

  assign cand  = ~base_mask & adj_r[f] & above_c & below_n;
  assign found = |cand;

  always_comb begin
    cp = '0;
    for (int i = MAX_V - 1; i >= 0; i--) begin
      if (cand[i]) begin
        cp = VW'(i);
      end
    end
  end

  assign new_mask = base_mask | (ONE_HOT0 << f) | (ONE_HOT0 << cp);
  assign free     = ~new_mask & below_n;
  assign complete = ~|free;

  always_comb begin
    nf = '0;
    for (int i = MAX_V - 1; i >= 0; i--) begin
      if (free[i]) begin
        nf = VW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= '0;
    end else if (cmd.cfg_write) begin
      vcount_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      for (int i = 0; i < MAX_V; i++) begin
        adj_r[i] <= '0;
      end
    end else if (cmd.load && pair_ok) begin
      adj_r[VW'(lo_v)] <= adj_r[VW'(lo_v)] | (ONE_HOT0 << hi_v);
    end
  end

  // stack entries carry no reset: each level is written before it is read
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      stk_f_r[0] <= '0;
      stk_c_r[0] <= '0;
    end else if (cmd.step && found) begin
      stk_c_r[top] <= cp;
      if (!complete) begin
        stk_f_r[push_idx] <= nf;
        stk_c_r[push_idx] <= nf;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r  <= '0;
      mask_r   <= '0;
      resume_r <= 1'b0;
      count_r  <= '0;
    end else if (cmd.init) begin
      depth_r  <= DW'(1);
      mask_r   <= '0;
      resume_r <= 1'b0;
      count_r  <= (n_eff == '0) ? pmc_pkg::COUNT_W'(1) : '0;
    end else if (cmd.step) begin
      if (found) begin
        resume_r <= 1'b0;
        if (complete) begin
          mask_r <= base_mask;
          if (count_r != '1) begin
            count_r <= count_r + pmc_pkg::COUNT_W'(1);
          end
        end else begin
          mask_r  <= new_mask;
          depth_r <= depth_r + DW'(1);
        end
      end else begin
        mask_r   <= base_mask;
        depth_r  <= depth_r - DW'(1);
        resume_r <= 1'b1;
      end
    end
  end

  assign status.found     = found;
  assign status.depth_one = (depth_r == DW'(1));
  assign status.n_zero    = (n_eff == '0);
  assign count            = count_r;

endmodule
`default_nettype wire

>>> rtl/perfect_matching_counter_unit.sv
// Top level of the perfect matching counter: sequencer plus search datapath.
//
//   channel   ports                                   handshake
//   --------  --------------------------------------  ------------------------
//   input     in_vertex_a/b, in_pair_valid, in_last_item  start & !busy
//   result    out_matching_count                      out_valid, one cycle
//   config    cfg_data (vertex count)                 cfg_valid & cfg_ready
//
// A pair beat without in_last_item is stored; the block stays idle.
// A beat with in_last_item stores its pair, runs the backtracking steps
// (one try, push or pop per cycle through the single search unit; none
// with no vertices), then shows the count and wipes the rows.
// Reset (rst_n low, synchronous) clears rows, vertex count and control.
// The result is shown for exactly one cycle; the receiver cannot stall it.
// cfg_ready is high only while idle.
`default_nettype none
module perfect_matching_counter_unit #(
  parameter int unsigned MAX_VERTICES = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [pmc_pkg::VERTEX_W-1:0]      in_vertex_a,
  input  wire logic [pmc_pkg::VERTEX_W-1:0]      in_vertex_b,
  input  wire logic                              in_pair_valid,
  input  wire logic                              in_last_item,
  output logic                                   out_valid,
  output logic [pmc_pkg::COUNT_W-1:0]            out_matching_count,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [pmc_pkg::CFG_W-1:0]         cfg_data
);

  pmc_pkg::dp_cmd_t    cmd;
  pmc_pkg::dp_status_t status;

  // sequencer: accept beats, drive search steps, strobe the result
  pmc_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_last_item (in_last_item),
    .status       (status),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cmd          (cmd),
    .busy         (busy),
    .out_valid    (out_valid)
  );

  // storage and one-step search logic
  pmc_datapath #(
    .MAX_V (MAX_VERTICES)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .cfg_data      (cfg_data),
    .in_vertex_a   (in_vertex_a),
    .in_vertex_b   (in_vertex_b),
    .in_pair_valid (in_pair_valid),
    .status        (status),
    .count         (out_matching_count)
  );

`ifndef ASSERT_OFF
  // a last beat always starts a busy period
  a_last_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_last_item) |=> busy)
    else $error("last beat accepted but block not busy");

  // after the result strobe the block is free for the next case
  a_idle_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy)
    else $error("block still busy after result");

  // one strobe per case
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // a result only comes out of a busy period
  a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (busy && !cfg_ready))
    else $error("result outside a busy period");
`endif

endmodule
`default_nettype wire

>>> bench/matching_count_checker.sv
// Channel monitor with its own matching counter: predicts every count and compares.
module matching_count_checker #(
  parameter int unsigned MAX_VERTICES = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic                          busy,
  input  wire logic [pmc_pkg::VERTEX_W-1:0]  in_vertex_a,
  input  wire logic [pmc_pkg::VERTEX_W-1:0]  in_vertex_b,
  input  wire logic                          in_pair_valid,
  input  wire logic                          in_last_item,
  input  wire logic                          out_valid,
  input  wire logic [pmc_pkg::COUNT_W-1:0]   out_matching_count,
  input  wire logic                          cfg_valid,
  input  wire logic                          cfg_ready,
  input  wire logic [pmc_pkg::CFG_W-1:0]     cfg_data,
  output int unsigned                        fail_count,
  output int unsigned                        count_pending,
  output int unsigned                        counts_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [pmc_pkg::COUNT_W-1:0] COUNT_CEIL = '1;

  logic [MAX_VERTICES-1:0]        adjacency [MAX_VERTICES];
  logic [pmc_pkg::CFG_W-1:0]      vertex_count;
  logic [pmc_pkg::COUNT_W-1:0]    expected_counts [$];
  int unsigned                    ways [1 << MAX_VERTICES];
  int unsigned                    mismatches = 0;
  int unsigned                    checked = 0;

  function automatic int unsigned active_vertices();
    return (vertex_count > MAX_VERTICES) ? MAX_VERTICES : int'(vertex_count);
  endfunction

  // Ways to reach each partial matching; the lowest free vertex always takes a partner.
  function automatic logic [pmc_pkg::COUNT_W-1:0] count_perfect_matchings(
    input int unsigned n);
    int unsigned full;
    int unsigned m;
    int unsigned c;
    int unsigned lowest;
    int unsigned joined;
    logic [pmc_pkg::COUNT_W-1:0] total;
    full = (1 << n) - 1;
    for (m = 0; m <= full; m++) ways[m] = 0;
    ways[0] = 1;
    for (m = 0; m < full; m++) begin
      if (ways[m] != 0) begin
        lowest = 0;
        while (m[lowest]) lowest++;
        for (c = lowest + 1; c < n; c++) begin
          if (!m[c] && adjacency[lowest][c]) begin
            joined = m | (1 << lowest) | (1 << c);
            ways[joined] += ways[m];
          end
        end
      end
    end
    if (ways[full] > COUNT_CEIL) total = COUNT_CEIL;
    else total = pmc_pkg::COUNT_W'(ways[full]);
    return total;
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  always @(posedge clk) begin : watch
    int unsigned n;
    logic [pmc_pkg::COUNT_W-1:0] want;
    if (!rst_n) begin
      foreach (adjacency[i]) adjacency[i] = '0;
      vertex_count = '0;
      expected_counts.delete();
    end else begin
      if (out_valid) begin
        if (expected_counts.size() == 0) begin
          flag_mismatch($sformatf("count %0d with no case awaiting it", out_matching_count));
        end else begin
          want = expected_counts.pop_front();
          checked++;
          if (out_matching_count !== want)
            flag_mismatch($sformatf("matching_count %0d, predicted %0d",
                                    out_matching_count, want));
        end
      end
      if (cfg_valid && cfg_ready) vertex_count = cfg_data;
      if (start && !busy) begin
        n = active_vertices();
        if (in_pair_valid && in_vertex_a != in_vertex_b &&
            in_vertex_a < n && in_vertex_b < n) begin
          if (in_vertex_a < in_vertex_b) adjacency[in_vertex_a][in_vertex_b] = 1'b1;
          else adjacency[in_vertex_b][in_vertex_a] = 1'b1;
        end
        if (in_last_item) begin
          expected_counts.push_back(count_perfect_matchings(n));
          foreach (adjacency[i]) adjacency[i] = '0;
        end
      end
    end
    fail_count     <= mismatches;
    count_pending  <= expected_counts.size();
    counts_checked <= checked;
  end

endmodule

>>> bench/testbench.sv
// Stimulus, watchdog and verdict for the perfect matching counter.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_VERTICES = 16;
  // Slowest search here is a complete graph on 12 vertices.
  localparam int unsigned IDLE_LIMIT   = 400_000;
  localparam int unsigned ITEM_TARGET  = 700;

  typedef enum int {GRAPH_SPARSE, GRAPH_PLANTED, GRAPH_COMPLETE} graph_kind_t;
  typedef enum int {NOISE_SELF, NOISE_OUT_OF_RANGE, NOISE_EMPTY, NOISE_WILD} noise_kind_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         start = 1'b0;
  logic                         busy;
  logic [pmc_pkg::VERTEX_W-1:0] in_vertex_a = '0;
  logic [pmc_pkg::VERTEX_W-1:0] in_vertex_b = '0;
  logic                         in_pair_valid = 1'b0;
  logic                         in_last_item = 1'b0;
  logic                         out_valid;
  logic [pmc_pkg::COUNT_W-1:0]  out_matching_count;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [pmc_pkg::CFG_W-1:0]    cfg_data = '0;

  int unsigned fail_count;
  int unsigned count_pending;
  int unsigned counts_checked;

  // Beats of the case being built; the final entry goes out as the closing beat.
  logic [pmc_pkg::VERTEX_W-1:0] case_a [$];
  logic [pmc_pkg::VERTEX_W-1:0] case_b [$];
  logic                         case_valid [$];

  int unsigned beats_sent = 0;
  int unsigned cases_run = 0;
  int unsigned idle_cycles = 0;
  bit          steady = 1'b0;  // no gaps at all for the current case

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  perfect_matching_counter_unit #(
    .MAX_VERTICES(MAX_VERTICES)
  ) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_vertex_a       (in_vertex_a),
    .in_vertex_b       (in_vertex_b),
    .in_pair_valid     (in_pair_valid),
    .in_last_item      (in_last_item),
    .out_valid         (out_valid),
    .out_matching_count(out_matching_count),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data)
  );

  matching_count_checker #(
    .MAX_VERTICES(MAX_VERTICES)
  ) count_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_vertex_a       (in_vertex_a),
    .in_vertex_b       (in_vertex_b),
    .in_pair_valid     (in_pair_valid),
    .in_last_item      (in_last_item),
    .out_valid         (out_valid),
    .out_matching_count(out_matching_count),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data),
    .fail_count        (fail_count),
    .count_pending     (count_pending),
    .counts_checked    (counts_checked)
  );

  // Reset the idle count on any beat on any channel; give up when it runs out.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
      $display("testbench: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Mostly back to back or short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // Append one beat; the pair is symmetric, so flip its order at random.
  task automatic queue_pair(input int unsigned a, b, input int unsigned carries_pair);
    if ($urandom_range(0, 1)) begin
      case_a.push_back(pmc_pkg::VERTEX_W'(b));
      case_b.push_back(pmc_pkg::VERTEX_W'(a));
    end else begin
      case_a.push_back(pmc_pkg::VERTEX_W'(a));
      case_b.push_back(pmc_pkg::VERTEX_W'(b));
    end
    case_valid.push_back(carries_pair != 0);
  endtask

  // Append a beat the counter must ignore, or a fully random one.
  task automatic queue_noise(input int unsigned n);
    noise_kind_t kind;
    int unsigned v;
    kind = noise_kind_t'($urandom_range(0, 3));
    if (kind == NOISE_OUT_OF_RANGE && n >= 16) kind = NOISE_WILD;
    v = $urandom_range(0, 15);
    case (kind)
      NOISE_SELF:         queue_pair(v, v, 1);
      NOISE_OUT_OF_RANGE: queue_pair($urandom_range(n, 15), v, 1);
      NOISE_EMPTY:        queue_pair($urandom_range(0, 15), v, 0);
      default:            queue_pair($urandom_range(0, 15), v, $urandom_range(0, 1));
    endcase
  endtask

  // Hold start and the fields until the block takes the beat.
  task automatic drive_beat(input logic [pmc_pkg::VERTEX_W-1:0] a, b,
                            input logic carries_pair, last);
    int unsigned gap;
    gap = steady ? 0 : pick_gap();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    in_vertex_a   <= a;
    in_vertex_b   <= b;
    in_pair_valid <= carries_pair;
    in_last_item  <= last;
    do @(posedge clk); while (busy);
    beats_sent++;
  endtask

  // Write the vertex count once the block has drained.
  task automatic load_vertex_count(input logic [pmc_pkg::CFG_W-1:0] vcount);
    int unsigned gap;
    @(posedge clk);
    while (count_pending != 0) @(posedge clk);
    // let a trailing pair beat settle before the write
    repeat (3) @(posedge clk);
    gap = steady ? 0 : pick_gap();
    repeat (gap) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= vcount;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Configure, send the queued beats with the last one marked, drop start.
  task automatic play_case(input int unsigned vcount);
    int unsigned i;
    load_vertex_count(pmc_pkg::CFG_W'(vcount));
    if (case_a.size() == 0) queue_pair($urandom_range(0, 15), $urandom_range(0, 15), 0);
    for (i = 0; i < case_a.size(); i++)
      drive_beat(case_a[i], case_b[i], case_valid[i], i == case_a.size() - 1);
    start <= 1'b0;
    case_a.delete();
    case_b.delete();
    case_valid.delete();
    cases_run++;
  endtask

  // Build a graph on n vertices: sparse random, a planted perfect matching plus
  // extras, or complete (12 vertices at most). At times mix in noise beats, shuffle, then close the case.
  task automatic build_random_case(input int unsigned n);
    graph_kind_t kind;
    int unsigned perm [16];
    int unsigned i, j, k, pick;
    logic [pmc_pkg::VERTEX_W-1:0] ta, tb;
    logic tv;
    kind = graph_kind_t'($urandom_range(0, 2));
    if (kind == GRAPH_COMPLETE && n > 12) kind = GRAPH_PLANTED;
    case (kind)
      GRAPH_SPARSE: begin
        k = $urandom_range(0, (n <= 10) ? n * (n - 1) / 2 : 2 * n);
        for (i = 0; i < k; i++) begin
          if (n >= 2) queue_pair($urandom_range(0, n - 1), $urandom_range(0, n - 1), 1);
          else queue_noise(n);
        end
      end
      GRAPH_PLANTED: begin
        for (i = 0; i < n; i++) perm[i] = i;
        for (i = n; i > 1; i--) begin
          pick = $urandom_range(0, i - 1);
          k = perm[i - 1];
          perm[i - 1] = perm[pick];
          perm[pick] = k;
        end
        for (i = 0; i + 1 < n; i += 2) queue_pair(perm[i], perm[i + 1], 1);
        k = (n >= 2) ? $urandom_range(0, n) : 0;
        for (i = 0; i < k; i++)
          queue_pair($urandom_range(0, n - 1), $urandom_range(0, n - 1), 1);
      end
      default: begin
        for (i = 0; i < n; i++)
          for (j = i + 1; j < n; j++) queue_pair(i, j, 1);
      end
    endcase
    if ($urandom_range(0, 3) == 0) begin
      k = $urandom_range(1, 3);
      for (i = 0; i < k; i++) queue_noise(n);
    end
    for (i = case_a.size(); i > 1; i--) begin
      pick = $urandom_range(0, i - 1);
      ta = case_a[i - 1]; tb = case_b[i - 1]; tv = case_valid[i - 1];
      case_a[i - 1] = case_a[pick];
      case_b[i - 1] = case_b[pick];
      case_valid[i - 1] = case_valid[pick];
      case_a[pick] = ta; case_b[pick] = tb; case_valid[pick] = tv;
    end
    // half the time (always if empty) an empty closing beat is added, else the last shuffled beat closes
    if (case_a.size() == 0 || $urandom_range(0, 1))
      queue_pair($urandom_range(0, 15), $urandom_range(0, 15), 0);
  endtask

  initial begin : stimulus
    int unsigned roll;
    int unsigned vcount;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // No vertices: the empty graph has exactly one matching.
    queue_pair(15, 15, 0);
    play_case(0);
    // Two vertices: drop the self pair, count the pair on the closing beat.
    queue_pair(1, 1, 1);
    queue_pair(0, 1, 1);
    play_case(2);
    // Odd vertex count: a triangle still gives zero.
    queue_pair(0, 1, 1);
    queue_pair(1, 2, 1);
    queue_pair(0, 2, 1);
    queue_pair(2, 1, 0);
    play_case(3);
    // Out of range pairs and empty beats leave the store alone.
    queue_pair(3, 2, 1);
    queue_pair(0, 4, 1);
    queue_pair(15, 1, 1);
    queue_pair(0, 2, 0);
    queue_pair(1, 0, 1);
    play_case(4);
    // Register above the limit clamps to sixteen vertices; vertex 15 in use.
    for (int unsigned i = 0; i < 8; i++) queue_pair(i, 15 - i, 1);
    play_case(31);
    // A lone vertex cannot be matched.
    queue_pair(0, 0, 1);
    play_case(1);

    // Random cases: mostly small graphs, some at full size, a few clamped counts.
    while (beats_sent < ITEM_TARGET) begin
      steady = ($urandom_range(0, 3) == 0);
      roll = $urandom_range(0, 99);
      if (roll < 70) vcount = $urandom_range(0, 10);
      else if (roll < 90) vcount = $urandom_range(11, 16);
      else vcount = $urandom_range(17, 31);
      build_random_case((vcount > MAX_VERTICES) ? MAX_VERTICES : vcount);
      play_case(vcount);
    end

    // Drain: wait for the last count, then keep watching for stray strobes.
    @(posedge clk);
    while (count_pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d beats in %0d graph cases, vertex counts 0 to 31", beats_sent,
             cases_run);
    $display("compared %0d matching counts, %0d mismatches", counts_checked, fail_count);
    if (fail_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/pmc_pkg.sv
rtl/pmc_ctrl.sv
rtl/pmc_datapath.sv
rtl/perfect_matching_counter_unit.sv
bench/matching_count_checker.sv
bench/testbench.sv
